// ----- rtl/core/bdq_pkg.sv -----
// Shared constants, opcodes and controller/datapath interface types for the
// bounded deque with search. No dependencies.
package bdq_pkg;

  // Store geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Port widths fixed by the word format
  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OUT_CNT_W = 5;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POPW = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch request word, clear result
    logic push;        // write value at front or back, update ring
    logic pop_rd;      // issue read of the entry to be popped
    logic pop_commit;  // take read data as popped value, update ring
    logic scan_start;  // read first stored entry for a query
    logic scan_step;   // read next stored entry
    logic set_err;     // flag request as failed
    logic set_found;   // flag query as hit
    logic out_load;    // move result into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            match;
    logic            last;
    logic            out_free;
  } status_t;

endpackage

// ----- rtl/core/bounded_deque_with_search.sv -----
// Bounded deque with search: push and pop at both ends, membership query.
// Result path: pushes, failed requests and unknown opcodes pass through execute and finish;
// pops add a read-wait state, queries add a scan of k entries (0..16, one compared per cycle).
// One request in flight: the next is accepted only after the result enters the output register
// and the controller is back in idle; a result waits in finish while the output is not free.
// Reset (rst_ni low, async) empties the store; entries have no reset value.
module bounded_deque_with_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic [bdq_pkg::VAL_W-1:0]         item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bdq_pkg::VAL_W-1:0]         popped_value_o,
  output logic                              found_o,
  output logic                              now_empty_o,
  output logic [bdq_pkg::OUT_CNT_W-1:0]     entry_count_o,
  output logic                              error_o
);
  import bdq_pkg::*;

  cmd_t    cmd;
  status_t sts;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .found_o        (found_o),
    .now_empty_o    (now_empty_o),
    .entry_count_o  (entry_count_o),
    .error_o        (error_o)
  );

endmodule

// ----- rtl/core/bdq_ctrl.sv -----
// Request sequencer for the bounded deque: steps each request through
// execute, pop read, query scan and result hand-off. Uses bdq_pkg.
module bdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bdq_pkg::status_t sts_i,
  output bdq_pkg::cmd_t    cmd_o
);
  import bdq_pkg::*;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (sts_i.full) begin
              cmd_o.set_err = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
            end
            state_d = S_FIN;
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (sts_i.empty) begin
              cmd_o.set_err = 1'b1;
              state_d       = S_FIN;
            end else begin
              cmd_o.pop_rd = 1'b1;
              state_d      = S_POPW;
            end
          end
          OP_QUERY: begin
            if (sts_i.empty) begin
              state_d = S_FIN;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_POPW: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = S_FIN;
      end
      S_SCAN: begin
        priority if (sts_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FIN;
        end else if (sts_i.last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- rtl/core/bdq_dp.sv -----
// Datapath of the bounded deque: entry memory, ring pointers, request and
// result registers and the output register. Uses bdq_pkg.
module bdq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::cmd_t                     cmd_i,
  output bdq_pkg::status_t                  sts_o,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic [bdq_pkg::VAL_W-1:0]         item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bdq_pkg::VAL_W-1:0]         popped_value_o,
  output logic                              found_o,
  output logic                              now_empty_o,
  output logic [bdq_pkg::OUT_CNT_W-1:0]     entry_count_o,
  output logic                              error_o
);
  import bdq_pkg::*;

  // Ring index helpers
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [OP_W-1:0]       op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]      front_q, front_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic                  res_err_q, res_found_q;
  logic [DATA_WIDTH-1:0] res_pop_q;
  logic                  out_valid_q, out_valid_d;
  logic [VAL_W-1:0]      out_pop_q;
  logic                  out_found_q, out_empty_q, out_err_q;
  logic [CNT_W-1:0]      out_count_q;

  logic                  is_front;
  logic                  full, empty;
  logic [IDX_W-1:0]      cnt_idx;
  logic [IDX_W-1:0]      wr_addr, rd_addr, pop_addr;
  logic                  rd_en;

  assign is_front = (op_q == OP_PUSH_FRONT) || (op_q == OP_POP_FRONT);
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign cnt_idx  = count_q[IDX_W-1:0];

  // Address selection
  assign wr_addr  = is_front ? ring_dec(front_q) : ring_add(front_q, cnt_idx);
  assign pop_addr = is_front ? front_q : ring_add(front_q, cnt_idx - IDX_W'(1));
  assign scan_d   = cmd_i.scan_start ? '0 : scan_q + IDX_W'(1);
  assign rd_addr  = cmd_i.pop_rd ? pop_addr : ring_add(front_q, scan_d);
  assign rd_en    = cmd_i.pop_rd || cmd_i.scan_start || cmd_i.scan_step;

  // Entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Ring pointer update
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push) begin
      if (is_front) begin
        front_d = wr_addr;
      end
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_commit) begin
      if (is_front) begin
        front_d = ring_add(front_q, IDX_W'(1));
      end
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Request word, scan position and result under construction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= opcode_i;
      val_q       <= item_value_i[DATA_WIDTH-1:0];
      res_err_q   <= 1'b0;
      res_found_q <= 1'b0;
      res_pop_q   <= '0;
    end else begin
      if (cmd_i.set_err) begin
        res_err_q <= 1'b1;
      end
      if (cmd_i.set_found) begin
        res_found_q <= 1'b1;
      end
      if (cmd_i.pop_commit) begin
        res_pop_q <= rd_data_q;
      end
    end
    if (cmd_i.scan_start || cmd_i.scan_step) begin
      scan_q <= scan_d;
    end
  end

  // Output register: hold the word until taken
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pop_q   <= VAL_W'(res_pop_q);
      out_found_q <= res_found_q;
      out_empty_q <= empty;
      out_count_q <= count_q;
      out_err_q   <= res_err_q;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.full     = full;
  assign sts_o.empty    = empty;
  assign sts_o.match    = (rd_data_q == val_q);
  assign sts_o.last     = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_pop_q;
  assign found_o        = out_found_q;
  assign now_empty_o    = out_empty_q;
  assign entry_count_o  = OUT_CNT_W'(out_count_q);
  assign error_o        = out_err_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !full)
    else $error("push issued on full store");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_rd || cmd_i.pop_commit || cmd_i.scan_start) |-> !empty)
    else $error("read issued on empty store");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push || cmd_i.pop_commit) |=> $stable(count_q))
    else $error("entry count changed without push or pop");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before taken");

endmodule
